### design/bit_vector_store_assert.svh
// Assertion macros shared by the bit vector store checkers.
// Each macro wraps one concurrent assertion clocked on a rising edge
// and disabled while the active-low reset is asserted.
`ifndef BIT_VECTOR_STORE_ASSERT_SVH
`define BIT_VECTOR_STORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BVS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bit_vector_store: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BVS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bit_vector_store: next-cycle check failed");

`endif

### design/bvs_pkg.sv
// Package for the bit vector store: field widths, operation and status
// codes, controller states and the command/flag structs between modules.
// No dependencies.
package bvs_pkg;

    localparam int WORD_BITS      = 64;
    localparam int POS_BITS       = 6;
    localparam int INDEX_BITS     = 12;
    localparam int LEN_BITS       = 13;
    localparam int WLEN_BITS      = 7;
    localparam int OP_BITS        = 3;
    localparam int IN_TDATA_BITS  = 88;
    localparam int OUT_TDATA_BITS = 72;

    localparam logic [LEN_BITS-1:0] LEN_RESET = 13'd4096;

    typedef enum logic [OP_BITS-1:0] {
        OP_CLEAR_ALL    = 3'd0,
        OP_WRITE_BIT    = 3'd1,
        OP_READ_BIT     = 3'd2,
        OP_WRITE_WORD   = 3'd3,
        OP_READ_WINDOW  = 3'd4,
        OP_TEST_ALL_SET = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_RANGE  = 2'd1,
        STAT_ALIGN  = 2'd2,
        STAT_LENGTH = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_FETCH,
        ST_MERGE,
        ST_TEST_RD,
        ST_TEST_CHK,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        ADDR_WORD,
        ADDR_NEXT,
        ADDR_CNT
    } addr_sel_t;

    typedef enum logic [1:0] {
        WR_ZERO,
        WR_WORD,
        WR_BIT
    } wr_sel_t;

    typedef struct packed {
        logic      capture;
        logic      mem_rd;
        logic      mem_wr;
        wr_sel_t   wr_sel;
        addr_sel_t addr_sel;
        logic      cnt_clr;
        logic      cnt_inc;
        logic      set_status;
        logic      set_bit_rd;
        logic      save_lo;
        logic      set_window;
        logic      merge;
        logic      set_all;
        logic      load_out;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic err;
        logic cnt_last;
        logic test_end;
        logic test_fail;
        logic next_needed;
        logic out_free;
    } flags_t;

    function automatic logic [WORD_BITS-1:0] low_ones(input logic [WLEN_BITS-1:0] n);
        if (n[WLEN_BITS-1]) begin
            return '1;
        end
        return (64'd1 << n[POS_BITS-1:0]) - 64'd1;
    endfunction

endpackage

### design/bvs_ctrl.sv
// Controller of the bit vector store: sequences the word memory sweeps,
// fetches and result hand-off. Depends on bvs_pkg.
module bvs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  bvs_pkg::flags_t flags,
    output bvs_pkg::cmd_t   cmd
);
    import bvs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT: begin
                // Zero every word after reset before the first transfer is taken.
                cmd.mem_wr   = 1'b1;
                cmd.wr_sel   = WR_ZERO;
                cmd.addr_sel = ADDR_CNT;
                if (flags.cnt_last) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.set_status = 1'b1;
                cmd.cnt_clr    = 1'b1;
                if (flags.err) begin
                    state_next = ST_RESULT;
                end else begin
                    case (flags.op)
                        OP_CLEAR_ALL: begin
                            state_next = ST_CLEAR;
                        end
                        OP_WRITE_BIT, OP_READ_BIT, OP_READ_WINDOW: begin
                            cmd.mem_rd   = 1'b1;
                            cmd.addr_sel = ADDR_WORD;
                            state_next   = ST_FETCH;
                        end
                        OP_WRITE_WORD: begin
                            cmd.mem_wr   = 1'b1;
                            cmd.wr_sel   = WR_WORD;
                            cmd.addr_sel = ADDR_WORD;
                            state_next   = ST_RESULT;
                        end
                        OP_TEST_ALL_SET: begin
                            state_next = ST_TEST_RD;
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                cmd.mem_wr   = 1'b1;
                cmd.wr_sel   = WR_ZERO;
                cmd.addr_sel = ADDR_CNT;
                if (flags.cnt_last) begin
                    state_next = ST_RESULT;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_FETCH: begin
                case (flags.op)
                    OP_WRITE_BIT: begin
                        cmd.mem_wr   = 1'b1;
                        cmd.wr_sel   = WR_BIT;
                        cmd.addr_sel = ADDR_WORD;
                        state_next   = ST_RESULT;
                    end
                    OP_READ_BIT: begin
                        cmd.set_bit_rd = 1'b1;
                        state_next     = ST_RESULT;
                    end
                    OP_READ_WINDOW: begin
                        if (flags.next_needed) begin
                            cmd.save_lo  = 1'b1;
                            cmd.mem_rd   = 1'b1;
                            cmd.addr_sel = ADDR_NEXT;
                            state_next   = ST_MERGE;
                        end else begin
                            cmd.set_window = 1'b1;
                            state_next     = ST_RESULT;
                        end
                    end
                    default: begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_MERGE: begin
                cmd.set_window = 1'b1;
                cmd.merge      = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_TEST_RD: begin
                if (flags.test_end) begin
                    cmd.set_all = 1'b1;
                    state_next  = ST_RESULT;
                end else begin
                    cmd.mem_rd   = 1'b1;
                    cmd.addr_sel = ADDR_CNT;
                    state_next   = ST_TEST_CHK;
                end
            end
            ST_TEST_CHK: begin
                if (flags.test_fail) begin
                    state_next = ST_RESULT;
                end else begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_TEST_RD;
                end
            end
            ST_RESULT: begin
                if (flags.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

### design/bvs_datapath.sv
// Datapath of the bit vector store: word memory, captured operation,
// length register, checks, window funnel shifter and output register.
// Depends on bvs_pkg; driven by bvs_ctrl.
module bvs_datapath #(
    parameter int MAX_BITS = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [bvs_pkg::IN_TDATA_BITS-1:0]  s_tdata,
    input  logic [bvs_pkg::OP_BITS-1:0]        s_tuser,
    input  logic                               cfg_wr_en,
    input  logic [bvs_pkg::LEN_BITS-1:0]       cfg_wr_data,
    input  bvs_pkg::cmd_t                      cmd,
    output bvs_pkg::flags_t                    flags,
    output logic                               m_tvalid,
    output logic [bvs_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    input  logic                               m_tready
);
    import bvs_pkg::*;

    localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CW        = $clog2(NUM_WORDS + 1);
    localparam int IW        = (AW > POS_BITS) ? AW : POS_BITS;
    localparam int CMPW      = (CW + POS_BITS > LEN_BITS) ? CW + POS_BITS : LEN_BITS;
    localparam int MAXW      = $clog2(MAX_BITS + 1);
    localparam int LCW       = (MAXW > LEN_BITS) ? MAXW : LEN_BITS;

    logic [LEN_BITS-1:0]   len_cfg_reg;
    op_t                   op_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic                  val_reg;
    logic [WORD_BITS-1:0]  data_reg;
    logic [WLEN_BITS-1:0]  wlen_reg;
    logic [CW-1:0]         cnt_reg;
    logic [WORD_BITS-1:0]  rdata_reg;
    logic [WORD_BITS-1:0]  lo_reg;
    logic [WORD_BITS-1:0]  rd_reg;
    logic                  all_reg;
    status_t               status_reg;
    logic                  m_tvalid_reg;
    logic [OUT_TDATA_BITS-1:0] m_tdata_reg;

    logic [WORD_BITS-1:0] mem [NUM_WORDS];

    logic [LEN_BITS-1:0]   len;
    logic [POS_BITS-1:0]   pos;
    logic [IW-1:0]         word_wide;
    logic [IW-1:0]         next_wide;
    logic [AW-1:0]         mem_addr;
    logic [WORD_BITS-1:0]  mem_wdata;
    logic [LEN_BITS-1:0]   next_start;
    status_t               status_chk;
    logic [CMPW-1:0]       start_cmp;
    logic [CMPW-1:0]       len_cmp;
    logic [CMPW-1:0]       diff;
    logic [WLEN_BITS-1:0]  need_n;
    logic [WORD_BITS-1:0]  need;
    logic [WORD_BITS-1:0]  win_lo;
    logic [WORD_BITS-1:0]  win_hi;
    logic [2*WORD_BITS-1:0] funnel;
    logic [WORD_BITS-1:0]  win;

    // A configured length above the store size acts as the store size.
    assign len = (LCW'(len_cfg_reg) > LCW'(MAX_BITS)) ? LEN_BITS'(MAX_BITS) : len_cfg_reg;

    assign pos        = idx_reg[POS_BITS-1:0];
    assign word_wide  = IW'(idx_reg[INDEX_BITS-1:POS_BITS]);
    assign next_wide  = word_wide + IW'(1);
    assign next_start = {7'(idx_reg[INDEX_BITS-1:POS_BITS]) + 7'd1, 6'd0};

    always_comb begin
        status_chk = STAT_OK;
        priority if ((op_reg == OP_WRITE_BIT || op_reg == OP_READ_BIT ||
                      op_reg == OP_WRITE_WORD || op_reg == OP_READ_WINDOW) &&
                     ({1'b0, idx_reg} >= len)) begin
            status_chk = STAT_RANGE;
        end else if (op_reg == OP_WRITE_WORD && pos != '0) begin
            status_chk = STAT_ALIGN;
        end else if (op_reg == OP_READ_WINDOW && wlen_reg > WLEN_BITS'(WORD_BITS)) begin
            status_chk = STAT_LENGTH;
        end else begin
            status_chk = STAT_OK;
        end
    end

    always_comb begin
        unique case (cmd.addr_sel)
            ADDR_WORD: mem_addr = word_wide[AW-1:0];
            ADDR_NEXT: mem_addr = next_wide[AW-1:0];
            ADDR_CNT:  mem_addr = cnt_reg[AW-1:0];
            default:   mem_addr = word_wide[AW-1:0];
        endcase
    end

    always_comb begin
        unique case (cmd.wr_sel)
            WR_ZERO: mem_wdata = '0;
            WR_WORD: mem_wdata = data_reg;
            WR_BIT:  mem_wdata = (rdata_reg & ~(64'd1 << pos)) | (64'(val_reg) << pos);
            default: mem_wdata = '0;
        endcase
    end

    // Test-all-set walk: the word at cnt_reg must have its first
    // min(len - start, WORD_BITS) bits set.
    assign start_cmp = CMPW'({cnt_reg, 6'd0});
    assign len_cmp   = CMPW'(len);
    assign diff      = len_cmp - start_cmp;
    assign need_n    = (diff >= CMPW'(WORD_BITS)) ? WLEN_BITS'(WORD_BITS) : diff[WLEN_BITS-1:0];
    assign need      = low_ones(need_n);

    // Window: funnel shift of the addressed word and its successor.
    assign win_lo = cmd.merge ? lo_reg : rdata_reg;
    assign win_hi = cmd.merge ? rdata_reg : '0;
    assign funnel = {win_hi, win_lo} >> pos;
    assign win    = funnel[WORD_BITS-1:0] & low_ones(wlen_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_cfg_reg <= LEN_RESET;
        end else if (cfg_wr_en) begin
            len_cfg_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_clr) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= op_t'(s_tuser);
            idx_reg  <= s_tdata[11:0];
            val_reg  <= s_tdata[12];
            data_reg <= s_tdata[76:13];
            wlen_reg <= s_tdata[83:77];
        end
        if (cmd.save_lo) begin
            lo_reg <= rdata_reg;
        end
        if (cmd.set_status) begin
            status_reg <= status_chk;
            rd_reg     <= '0;
            all_reg    <= 1'b0;
        end
        if (cmd.set_bit_rd) begin
            rd_reg <= WORD_BITS'(rdata_reg[pos]);
        end
        if (cmd.set_window) begin
            rd_reg <= win;
        end
        if (cmd.set_all) begin
            all_reg <= 1'b1;
        end
        if (cmd.load_out) begin
            m_tdata_reg <= {5'd0, status_reg, all_reg, rd_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign flags.op          = op_reg;
    assign flags.err         = (status_chk != STAT_OK);
    assign flags.cnt_last    = (cnt_reg == CW'(NUM_WORDS - 1));
    assign flags.test_end    = (start_cmp >= len_cmp);
    assign flags.test_fail   = ((rdata_reg & need) != need);
    assign flags.next_needed = (pos != '0) && (next_start < len);
    assign flags.out_free    = !m_tvalid_reg || m_tready;

endmodule

### design/bit_vector_store.sv
// Top level of the bit vector store: joins the controller and the datapath.
// Depends on bvs_pkg, bvs_ctrl and bvs_datapath.
//
// A bit vector of up to MAX_BITS bits kept in a single-port memory of 64-bit
// words with a registered read. After reset the block zeroes every memory word
// and keeps s_tready low meanwhile; length writes are taken at any time. One
// result transfer follows each input transfer; a new input is taken once
// the previous operation is done, also while its result waits on m_tready.
// Write word writes the memory directly; read or write bit first reads the
// addressed word; read window also reads the next word when the index is not
// word aligned and that word starts inside the vector (the second word costs
// one more memory read); clear all writes every word; test all set reads the
// words in use in turn and stops at the first word in use with a clear bit.
// The memory port serves one word read or write per cycle. Results wait in
// an output register.
module bit_vector_store #(
    parameter int MAX_BITS = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [11:0] bit_index, [12] bit_value, [76:13] word_data, [83:77] window_length
    input  logic [bvs_pkg::IN_TDATA_BITS-1:0]  s_tdata,
    // [2:0] operation
    input  logic [bvs_pkg::OP_BITS-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [63:0] read_data, [64] all_set, [66:65] status
    output logic [bvs_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    input  logic                               cfg_wr_en,
    // vector_length
    input  logic [bvs_pkg::LEN_BITS-1:0]       cfg_wr_data
);
    import bvs_pkg::*;

    cmd_t   cmd;
    flags_t flags;

    bvs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    bvs_datapath #(
        .MAX_BITS (MAX_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .flags       (flags),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tready    (m_tready)
    );

endmodule

### design/bvs_checker.sv
// Port-level checks for the bit vector store, bound to the top level.
// Depends on bvs_pkg, bit_vector_store_assert.svh and bit_vector_store.
`include "bit_vector_store_assert.svh"

module bvs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);
    import bvs_pkg::*;

    logic [63:0] rd;
    logic        all_set;
    status_t     stat;
    logic [4:0]  pad;

    assign rd      = m_tdata[63:0];
    assign all_set = m_tdata[64];
    assign stat    = status_t'(m_tdata[66:65]);
    assign pad     = m_tdata[71:67];

    // A result that is not taken stays on the bus unchanged.
    `BVS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A failed check returns no data and no all-set flag.
    `BVS_ASSERT_SAME(a_err_clean, aclk, aresetn, m_tvalid && stat != STAT_OK, !all_set && rd == '0)

    // The all-set answer comes only from a successful test, which returns no data.
    `BVS_ASSERT_SAME(a_all_alone, aclk, aresetn, m_tvalid && all_set, stat == STAT_OK && rd == '0)

    // Padding bits of a result are zero.
    `BVS_ASSERT_SAME(a_pad_zero, aclk, aresetn, m_tvalid, pad == '0)

endmodule

bind bit_vector_store bvs_checker u_bvs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/sv/bvs_result_checker.sv
// Result checker for the bit vector store: keeps its own copy of the bit vector
// and the length register, predicts the result of every input transfer and compares it.
// Depends on bvs_pkg.
module bvs_result_checker #(
    parameter int MAX_BITS = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [bvs_pkg::IN_TDATA_BITS-1:0]  s_tdata,
    input  logic [bvs_pkg::OP_BITS-1:0]        s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [bvs_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [bvs_pkg::LEN_BITS-1:0]       cfg_wr_data,
    output int                                 error_count,
    output int                                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import bvs_pkg::*;

    localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;

    typedef struct packed {
        logic [WORD_BITS-1:0] read_data;
        logic                 all_set;
        status_t              status;
    } bvs_result_t;

    logic [WORD_BITS-1:0] stored_words [NUM_WORDS];
    logic [LEN_BITS-1:0]  vector_length;
    bvs_result_t          expected_results [$];

    function automatic logic [WORD_BITS-1:0] ones_below(int unsigned n);
        if (n >= WORD_BITS) begin
            return '1;
        end
        return (64'd1 << n) - 64'd1;
    endfunction

    // Applies one operation to the local copy of the vector and returns its result.
    function automatic bvs_result_t apply_operation(logic [OP_BITS-1:0] op,
                                                    logic [INDEX_BITS-1:0] idx,
                                                    logic val,
                                                    logic [WORD_BITS-1:0] data,
                                                    logic [WLEN_BITS-1:0] wlen);
        bvs_result_t          res;
        int unsigned          used;
        int unsigned          w;
        int unsigned          pos;
        int unsigned          k;
        logic [WORD_BITS-1:0] window;
        logic [WORD_BITS-1:0] mask;
        res = '0;
        used = (vector_length > MAX_BITS) ? MAX_BITS : vector_length;
        w = idx / WORD_BITS;
        pos = idx % WORD_BITS;
        if (op >= OP_WRITE_BIT && op <= OP_READ_WINDOW && (idx >= used || w >= NUM_WORDS)) begin
            res.status = STAT_RANGE;
        end else begin
            case (op)
                OP_CLEAR_ALL: begin
                    for (k = 0; k < NUM_WORDS; k++) begin
                        stored_words[k] = '0;
                    end
                end
                OP_WRITE_BIT: begin
                    stored_words[w][pos] = val;
                end
                OP_READ_BIT: begin
                    res.read_data = {63'd0, stored_words[w][pos]};
                end
                OP_WRITE_WORD: begin
                    if (pos != 0) begin
                        res.status = STAT_ALIGN;
                    end else begin
                        stored_words[w] = data;
                    end
                end
                OP_READ_WINDOW: begin
                    if (wlen > WORD_BITS) begin
                        res.status = STAT_LENGTH;
                    end else begin
                        window = stored_words[w] >> pos;
                        // The following word only counts if it starts inside the vector.
                        if (pos != 0 && (w + 1) * WORD_BITS < used && w + 1 < NUM_WORDS) begin
                            window |= stored_words[w + 1] << (WORD_BITS - pos);
                        end
                        res.read_data = window & ones_below(wlen);
                    end
                end
                OP_TEST_ALL_SET: begin
                    res.all_set = 1'b1;
                    for (k = 0; k < NUM_WORDS && res.all_set; k++) begin
                        if (k * WORD_BITS < used) begin
                            mask = ones_below(used - k * WORD_BITS);
                            if ((stored_words[k] & mask) != mask) begin
                                res.all_set = 1'b0;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        bvs_result_t actual;
        bvs_result_t wanted;
        if (!aresetn) begin
            for (int k = 0; k < NUM_WORDS; k++) begin
                stored_words[k] = '0;
            end
            vector_length = LEN_RESET;
            expected_results.delete();
            error_count = 0;
        end else begin
            // The result side is handled first: a result never belongs to an
            // input transfer taken at the same edge.
            if (m_tvalid && m_tready) begin
                actual.read_data = m_tdata[63:0];
                actual.all_set = m_tdata[64];
                actual.status = status_t'(m_tdata[66:65]);
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_tdata);
                    error_count = error_count + 1;
                end else begin
                    wanted = expected_results.pop_front();
                    if (actual.read_data !== wanted.read_data) begin
                        $error("read_data: expected %h, got %h",
                               wanted.read_data, actual.read_data);
                        error_count = error_count + 1;
                    end
                    if (actual.all_set !== wanted.all_set) begin
                        $error("all_set: expected %0d, got %0d", wanted.all_set, actual.all_set);
                        error_count = error_count + 1;
                    end
                    if (actual.status !== wanted.status) begin
                        $error("status: expected %0d, got %0d", wanted.status, actual.status);
                        error_count = error_count + 1;
                    end
                end
            end
            if (cfg_wr_en) begin
                vector_length = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_operation(s_tuser, s_tdata[11:0], s_tdata[12],
                                                           s_tdata[76:13], s_tdata[83:77]));
            end
        end
        pending_count <= expected_results.size();
    end

endmodule

### tb/sv/tb_top.sv
// Testbench top for the bit vector store: clock, reset, length writes and
// directed plus random operations under varying stream idling and back pressure.
// Depends on bvs_pkg, bit_vector_store and bvs_result_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bvs_pkg::*;

    localparam int MAX_BITS = 4096;
    localparam logic [OP_BITS-1:0] OP_UNUSED_LO = 3'd6;
    localparam logic [OP_BITS-1:0] OP_UNUSED_HI = 3'd7;
    localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
    logic [OP_BITS-1:0]        s_tuser = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      cfg_wr_en = 1'b0;
    logic [LEN_BITS-1:0]       cfg_wr_data = '0;

    int          errors;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int unsigned items_sent = 0;
    int unsigned used_length = MAX_BITS;

    bit_vector_store #(.MAX_BITS(MAX_BITS)) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    bvs_result_checker #(.MAX_BITS(MAX_BITS)) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .error_count  (errors),
        .pending_count(pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Offers one operation and returns at the edge where its transfer completes.
    task automatic send_item(logic [OP_BITS-1:0] op, logic [INDEX_BITS-1:0] idx, logic val,
                             logic [WORD_BITS-1:0] data, logic [WLEN_BITS-1:0] wlen);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'd0, wlen, data, val, idx};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        items_sent++;
    endtask

    // The length register is only written once every result has come back.
    task automatic write_length(logic [LEN_BITS-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        used_length = (value > MAX_BITS) ? MAX_BITS : value;
    endtask

    function automatic logic [WORD_BITS-1:0] random_word();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 3) begin
            return ALL_ONES;
        end else if (pick == 3) begin
            return '0;
        end
        return {$urandom, $urandom};
    endfunction

    // Mostly an index inside the vector in use, sometimes anywhere.
    function automatic logic [INDEX_BITS-1:0] random_index();
        if (used_length == 0 || $urandom_range(9) == 0) begin
            return INDEX_BITS'($urandom_range(MAX_BITS - 1));
        end
        return INDEX_BITS'($urandom_range(used_length - 1));
    endfunction

    // Sets every word in use, maybe knocks one bit out, then asks whether all are set.
    task automatic fill_and_test();
        int unsigned w;
        for (w = 0; w * WORD_BITS < used_length; w++) begin
            send_item(OP_WRITE_WORD, INDEX_BITS'(w * WORD_BITS), 1'($urandom_range(1)),
                      ALL_ONES, WLEN_BITS'($urandom_range(127)));
        end
        if ($urandom_range(1) == 1) begin
            send_item(OP_WRITE_BIT, random_index(), 1'b0, random_word(),
                      WLEN_BITS'($urandom_range(127)));
        end
        send_item(OP_TEST_ALL_SET, random_index(), 1'($urandom_range(1)), random_word(),
                  WLEN_BITS'($urandom_range(127)));
    endtask

    task automatic random_step();
        int unsigned          pick;
        logic [INDEX_BITS-1:0] idx;
        logic [WLEN_BITS-1:0]  wlen;
        logic                  val;
        pick = $urandom_range(99);
        idx = random_index();
        val = 1'($urandom_range(1));
        wlen = ($urandom_range(9) == 0) ? WLEN_BITS'($urandom_range(127))
                                        : WLEN_BITS'($urandom_range(WORD_BITS));
        if (pick < 4) begin
            fill_and_test();
        end else if (pick < 6) begin
            send_item(OP_CLEAR_ALL, idx, val, random_word(), wlen);
        end else if (pick < 22) begin
            if ($urandom_range(9) != 0) begin
                idx = idx & ~INDEX_BITS'(WORD_BITS - 1);
            end
            send_item(OP_WRITE_WORD, idx, val, random_word(), wlen);
        end else if (pick < 42) begin
            send_item(OP_WRITE_BIT, idx, val, random_word(), wlen);
        end else if (pick < 57) begin
            send_item(OP_READ_BIT, idx, val, random_word(), wlen);
        end else if (pick < 85) begin
            send_item(OP_READ_WINDOW, idx, val, random_word(), wlen);
        end else if (pick < 95) begin
            send_item(OP_TEST_ALL_SET, idx, val, random_word(), wlen);
        end else begin
            send_item($urandom_range(1) ? OP_UNUSED_HI : OP_UNUSED_LO, idx, val,
                      random_word(), wlen);
        end
    endtask

    initial begin
        int unsigned length_plan [$] = '{100, 0, 8191, 64, 65, 4095, 127, 1, 4096};
        int          send_plan [4] = '{0, 59, 0, 37};
        int          recv_plan [4] = '{0, 0, 59, 37};
        int unsigned target;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        write_length(LEN_RESET);

        // Directed part on the full vector.
        send_item(OP_TEST_ALL_SET, 12'd0, 1'b0, '0, 7'd0);
        send_item(OP_WRITE_WORD, 12'd0, 1'b1, ALL_ONES, 7'd127);
        send_item(OP_WRITE_WORD, 12'd4032, 1'b0, 64'hA5A5_F00F_0123_4567, 7'd0);
        send_item(OP_READ_WINDOW, 12'd4032, 1'b0, '0, 7'd64);
        send_item(OP_READ_WINDOW, 12'd4000, 1'b0, '0, 7'd64);
        send_item(OP_READ_WINDOW, 12'd4095, 1'b0, '0, 7'd64);
        send_item(OP_READ_WINDOW, 12'd37, 1'b0, '0, 7'd0);
        send_item(OP_READ_WINDOW, 12'd63, 1'b0, '0, 7'd65);
        send_item(OP_READ_WINDOW, 12'd0, 1'b0, '0, 7'd127);
        send_item(OP_WRITE_WORD, 12'd65, 1'b0, ALL_ONES, 7'd0);
        send_item(OP_WRITE_BIT, 12'd4095, 1'b0, '0, 7'd0);
        send_item(OP_READ_BIT, 12'd4095, 1'b0, '0, 7'd0);
        send_item(OP_WRITE_BIT, 12'd1, 1'b0, ALL_ONES, 7'd0);
        send_item(OP_READ_BIT, 12'd1, 1'b1, '0, 7'd0);
        send_item(OP_READ_BIT, 12'd0, 1'b0, '0, 7'd0);
        send_item(OP_UNUSED_LO, 12'd4095, 1'b1, ALL_ONES, 7'd127);
        send_item(OP_UNUSED_HI, 12'd4095, 1'b1, ALL_ONES, 7'd127);
        send_item(OP_READ_WINDOW, 12'd63, 1'b0, '0, 7'd64);
        send_item(OP_CLEAR_ALL, 12'd0, 1'b0, '0, 7'd0);
        send_item(OP_READ_WINDOW, 12'd1, 1'b0, '0, 7'd64);

        // An empty vector: every index is out of range and the all-set test passes.
        write_length(13'd0);
        send_item(OP_READ_BIT, 12'd0, 1'b0, '0, 7'd0);
        send_item(OP_WRITE_WORD, 12'd0, 1'b0, ALL_ONES, 7'd0);
        send_item(OP_TEST_ALL_SET, 12'd0, 1'b0, '0, 7'd0);

        write_length(13'd1);
        send_item(OP_WRITE_BIT, 12'd0, 1'b1, '0, 7'd0);
        send_item(OP_TEST_ALL_SET, 12'd0, 1'b0, '0, 7'd0);
        send_item(OP_READ_WINDOW, 12'd0, 1'b0, '0, 7'd64);

        // A length above the maximum acts as the maximum.
        write_length(13'd8191);
        send_item(OP_READ_BIT, 12'd4095, 1'b0, '0, 7'd0);

        length_plan.push_back($urandom_range(1, MAX_BITS));
        foreach (length_plan[p]) begin
            write_length(LEN_BITS'(length_plan[p]));
            send_idle_pct <= send_plan[p % 4];
            recv_stall_pct <= recv_plan[p % 4];
            target = items_sent + 70;
            while (items_sent < target) begin
                random_step();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
